>>> design/bmsp_pkg.sv
// Shared types and codes for the salt-and-pepper mask block.
package bmsp_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_NOISE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    DIR_SYM  = 2'd0,
    DIR_ONE  = 2'd1,
    DIR_ZERO = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_BOUNDARY  = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FETCH,
    ST_NBR,
    ST_NBR_END,
    ST_DONE
  } seq_state_t;

  localparam int unsigned FieldRegW = 9;
  localparam logic [FieldRegW-1:0] FieldReset = 9'd256;

  typedef struct packed {
    logic [1:0]           noise_direction;
    logic                 boundary_only;
    logic [FieldRegW-1:0] field_width;
    logic [FieldRegW-1:0] field_height;
  } cfg_t;

endpackage

>>> design/bmsp_item_if.sv
// Input item channel.
interface bmsp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] row;
  logic [7:0] col;
  logic       pixel_in;
  logic       random_bit;

  modport source (output valid, func, row, col, pixel_in, random_bit, input ready);
  modport sink (input valid, func, row, col, pixel_in, random_bit, output ready);
endinterface

>>> design/bmsp_result_if.sv
// Result item channel.
interface bmsp_result_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic changed;
  logic coord_error;

  modport source (output valid, pixel_out, changed, coord_error, input ready);
  modport sink (input valid, pixel_out, changed, coord_error, output ready);
endinterface

>>> design/bmsp_cfg_if.sv
// Configuration write channel.
interface bmsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/bmsp_cfg.sv
// Configuration register file.
module bmsp_cfg
  import bmsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bmsp_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.noise_direction <= DIR_SYM;
      regs.boundary_only   <= 1'b0;
      regs.field_width     <= FieldReset;
      regs.field_height    <= FieldReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DIRECTION: regs.noise_direction <= cfg.data[1:0];
        REG_BOUNDARY:  regs.boundary_only   <= cfg.data[0];
        REG_WIDTH:     regs.field_width     <= cfg.data;
        REG_HEIGHT:    regs.field_height    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/bmsp_mem.sv
// Single-port bit memory with registered read.
module bmsp_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic          wdata,
  output logic          rdata
);

  localparam int unsigned Depth = 1 << AW;

  logic mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/bmsp_seq.sv
// Sequencer: decode, centre fetch, neighbour scan and write-back over one memory port.
module bmsp_seq
  import bmsp_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              regs,
  bmsp_item_if.sink         item,
  bmsp_result_if.source     result,
  output logic [2*$clog2(MAX_DIM)-1:0] mem_addr,
  output logic              mem_we,
  output logic              mem_wdata,
  input  logic              mem_rdata
);

  localparam int unsigned DW   = $clog2(MAX_DIM);
  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);

  seq_state_t state, state_next;

  logic [1:0]    func_q;
  logic [7:0]    row_q;
  logic [7:0]    col_q;
  logic          pin_q;
  logic          rnd_q;
  logic          cur;
  logic          target;
  logic          allow;
  logic          prev_ok;
  logic [1:0]    nbr_idx;
  logic          res_pixel;
  logic          res_changed;
  logic          res_err;

  logic [DIMW-1:0] w_eff;
  logic [DIMW-1:0] h_eff;
  logic [DW-1:0]   rr;
  logic [DW-1:0]   cc;
  logic            out_of_field;
  logic            target_c;
  logic            nbr_ok;
  logic [DW-1:0]   nbr_r;
  logic [DW-1:0]   nbr_c;
  logic            hit;
  logic            allow_final;
  logic            out_free;

  always_comb begin
    w_eff = (32'(regs.field_width) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(regs.field_width);
    h_eff = (32'(regs.field_height) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(regs.field_height);
    rr = DW'(row_q);
    cc = DW'(col_q);
    out_of_field = (32'(row_q) >= 32'(h_eff)) || (32'(col_q) >= 32'(w_eff));
    unique case (regs.noise_direction)
      DIR_ONE:  target_c = 1'b1;
      DIR_ZERO: target_c = 1'b0;
      default:  target_c = rnd_q;
    endcase
    unique case (nbr_idx)
      2'd0: begin
        nbr_ok = (row_q != 8'd0);
        nbr_r  = rr - DW'(1);
        nbr_c  = cc;
      end
      2'd1: begin
        nbr_ok = (col_q != 8'd0);
        nbr_r  = rr;
        nbr_c  = cc - DW'(1);
      end
      2'd2: begin
        nbr_ok = (32'(col_q) + 32'd1 < 32'(w_eff));
        nbr_r  = rr;
        nbr_c  = cc + DW'(1);
      end
      default: begin
        nbr_ok = (32'(row_q) + 32'd1 < 32'(h_eff));
        nbr_r  = rr + DW'(1);
        nbr_c  = cc;
      end
    endcase
    hit         = prev_ok && (mem_rdata != cur);
    allow_final = allow || hit;
    out_free    = !result.valid || result.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (func_q == FUNC_READ || func_q == FUNC_NOISE) begin
          state_next = out_of_field ? ST_DONE : ST_FETCH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FETCH: begin
        if (func_q == FUNC_NOISE && target_c != mem_rdata && regs.boundary_only) begin
          state_next = ST_NBR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_NBR: begin
        if (nbr_idx == 2'd3) begin
          state_next = ST_NBR_END;
        end
      end
      ST_NBR_END: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = (state == ST_IDLE);
    mem_addr   = {rr, cc};
    mem_we     = 1'b0;
    mem_wdata  = target;
    unique case (state)
      ST_DECODE: begin
        mem_wdata = pin_q;
        mem_we    = (func_q == FUNC_LOAD) && !out_of_field;
      end
      ST_FETCH: begin
        mem_wdata = target_c;
        mem_we    = (func_q == FUNC_NOISE) && (target_c != mem_rdata) && !regs.boundary_only;
      end
      ST_NBR: mem_addr = {nbr_r, nbr_c};
      ST_NBR_END: mem_we = allow_final;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          func_q <= item.func;
          row_q  <= item.row;
          col_q  <= item.col;
          pin_q  <= item.pixel_in;
          rnd_q  <= item.random_bit;
        end
      end
      ST_DECODE: begin
        res_pixel   <= 1'b0;
        res_changed <= 1'b0;
        res_err     <= 1'b0;
        if (func_q == FUNC_LOAD || func_q == FUNC_READ || func_q == FUNC_NOISE) begin
          res_err <= out_of_field;
          if (func_q == FUNC_LOAD && !out_of_field) begin
            res_pixel <= pin_q;
          end
        end
      end
      ST_FETCH: begin
        cur     <= mem_rdata;
        target  <= target_c;
        allow   <= 1'b0;
        prev_ok <= 1'b0;
        nbr_idx <= 2'd0;
        if (func_q == FUNC_NOISE && target_c != mem_rdata && !regs.boundary_only) begin
          res_pixel   <= target_c;
          res_changed <= 1'b1;
        end else begin
          res_pixel <= mem_rdata;
        end
      end
      ST_NBR: begin
        allow   <= allow || hit;
        prev_ok <= nbr_ok;
        nbr_idx <= nbr_idx + 2'd1;
      end
      ST_NBR_END: begin
        if (allow_final) begin
          res_pixel   <= target;
          res_changed <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          result.pixel_out   <= res_pixel;
          result.changed     <= res_changed;
          result.coord_error <= res_err;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/bit_mask_salt_pepper_noise.sv
// Top level of the salt-and-pepper noise block on a one-bit image mask.
//
// Channels: item (sink) carries func, row, col, pixel_in and random_bit;
// result (source) returns pixel_out, changed and coord_error, one per item;
// cfg (sink) writes noise direction, boundary-only mode, field width and
// field height by register index, and is always ready.
// One item is processed at a time through a single-port bit memory with a
// registered read. A load, an unused code or an out-of-field item passes
// through decode only; a read or a noisify without the neighbour check adds
// a centre fetch; when the boundary check runs, the four neighbours are then
// scanned, one memory read per cycle, before any write-back. Item ready returns
// the cycle the result register is loaded; no item is taken before then.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the sequencer holds its next
// result until the register is free.
// Reset clears the sequencer, the output valid and the registers
// (symmetric mode, boundary check off, field 256 by 256). The mask memory
// is not cleared: pixels must be loaded before they are read.
module bit_mask_salt_pepper_noise
  import bmsp_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic          clk,
  input  logic          rst,
  bmsp_cfg_if.sink      cfg,
  bmsp_item_if.sink     item,
  bmsp_result_if.source result
);

  localparam int unsigned AW = 2 * $clog2(MAX_DIM);

  cfg_t          regs;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_wdata;
  logic          mem_rdata;

  bmsp_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bmsp_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .item      (item),
    .result    (result),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  bmsp_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

>>> test/testbench.sv
// Self-checking bench for the salt-and-pepper mask block: directed items, then randomised phases.
module testbench;
  import bmsp_pkg::*;

  localparam int MaxDim = 256;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] DIR_ALT = 2'd3;
  localparam int NumFixed = 8;
  localparam int RandomPhases = 2;
  localparam int ItemsPerPhase = 140;

  typedef struct packed {
    logic pixel_out;
    logic changed;
    logic coord_error;
  } pix_result_t;

  class mask_scoreboard;
    bit mask_bits[MaxDim*MaxDim];
    bit loaded[MaxDim*MaxDim];
    cfg_t cfg;
    pix_result_t pending_results[$];
    int errors;

    function new();
      cfg.noise_direction = DIR_SYM;
      cfg.boundary_only = 1'b0;
      cfg.field_width = FieldReset;
      cfg.field_height = FieldReset;
      errors = 0;
    endfunction

    function int dim(logic [FieldRegW-1:0] v);
      return (v > MaxDim) ? MaxDim : int'(v);
    endfunction

    function void set_config(reg_idx_t idx, logic [8:0] data);
      case (idx)
        REG_DIRECTION: cfg.noise_direction = data[1:0];
        REG_BOUNDARY:  cfg.boundary_only = data[0];
        REG_WIDTH:     cfg.field_width = data;
        REG_HEIGHT:    cfg.field_height = data;
        default: ;
      endcase
    endfunction

    // a read or noisify may touch only pixels that were loaded
    function bit readable(logic [1:0] func, logic [7:0] row, logic [7:0] col);
      int w, h, r, c;
      w = dim(cfg.field_width);
      h = dim(cfg.field_height);
      r = int'(row);
      c = int'(col);
      if (func == FUNC_LOAD || func == FUNC_UNUSED) return 1'b1;
      if (r >= h || c >= w) return 1'b1;
      if (!loaded[r*MaxDim+c]) return 1'b0;
      if (func == FUNC_NOISE && cfg.boundary_only) begin
        if (r > 0 && !loaded[(r-1)*MaxDim+c]) return 1'b0;
        if (c > 0 && !loaded[r*MaxDim+c-1]) return 1'b0;
        if (c + 1 < w && !loaded[r*MaxDim+c+1]) return 1'b0;
        if (r + 1 < h && !loaded[(r+1)*MaxDim+c]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] func, logic [7:0] row, logic [7:0] col,
                            logic pin, logic rnd);
      int w, h, r, c, at;
      bit cur, target, allow;
      pix_result_t res;
      res = '0;
      w = dim(cfg.field_width);
      h = dim(cfg.field_height);
      r = int'(row);
      c = int'(col);
      at = r*MaxDim + c;
      if (func == FUNC_UNUSED) begin
      end else if (r >= h || c >= w) begin
        res.coord_error = 1'b1;
      end else if (func == FUNC_LOAD) begin
        mask_bits[at] = pin;
        loaded[at] = 1'b1;
        res.pixel_out = pin;
      end else begin
        cur = mask_bits[at];
        if (func == FUNC_NOISE) begin
          case (cfg.noise_direction)
            DIR_ONE:  target = 1'b1;
            DIR_ZERO: target = 1'b0;
            default:  target = rnd;
          endcase
          if (target != cur) begin
            allow = 1'b1;
            if (cfg.boundary_only) begin
              allow = 1'b0;
              if (r > 0 && mask_bits[at-MaxDim] != cur) allow = 1'b1;
              if (c > 0 && mask_bits[at-1] != cur) allow = 1'b1;
              if (c + 1 < w && mask_bits[at+1] != cur) allow = 1'b1;
              if (r + 1 < h && mask_bits[at+MaxDim] != cur) allow = 1'b1;
            end
            if (allow) begin
              mask_bits[at] = target;
              cur = target;
              res.changed = 1'b1;
            end
          end
        end
        res.pixel_out = cur;
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(pix_result_t got);
      pix_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: pixel_out=%0b changed=%0b coord_error=%0b",
                   got.pixel_out, got.changed, got.coord_error);
        return;
      end
      want = pending_results.pop_front();
      if (got.pixel_out !== want.pixel_out || got.changed !== want.changed ||
          got.coord_error !== want.coord_error) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel_out=%0b changed=%0b coord_error=%0b, got %0b %0b %0b",
                   want.pixel_out, want.changed, want.coord_error,
                   got.pixel_out, got.changed, got.coord_error);
      end
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bmsp_cfg_if    cfg_ch();
  bmsp_item_if   item_ch();
  bmsp_result_if res_ch();

  bit_mask_salt_pepper_noise u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mask_scoreboard sb = new();
  int items_sent = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;

  int ph_dir[NumFixed] = '{DIR_SYM, DIR_ONE, DIR_ZERO, DIR_ALT, DIR_SYM, DIR_ONE, DIR_SYM, DIR_ZERO};
  int ph_bnd[NumFixed] = '{0, 1, 1, 1, 1, 0, 1, 0};
  int ph_w[NumFixed]   = '{256, 12, 256, 1, 0, 511, 20, 2};
  int ph_h[NumFixed]   = '{256, 10, 256, 1, 5, 300, 256, 256};
  int ph_rb[NumFixed]  = '{246, 4, 0, 0, 0, 246, 248, 100};
  int ph_cb[NumFixed]  = '{246, 6, 0, 0, 0, 246, 14, 0};

  task automatic send(logic [1:0] func, logic [7:0] row, logic [7:0] col,
                      logic pin, logic rnd);
    int gap;
    items_sent++;
    if (items_sent % 40 == 0) quiet_send = ($urandom_range(0, 2) == 0);
    gap = quiet_send ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.func <= func;
    item_ch.row <= row;
    item_ch.col <= col;
    item_ch.pixel_in <= pin;
    item_ch.random_bit <= rnd;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(func, row, col, pin, rnd);
  endtask

  task automatic send_random_item(int rb, int cb);
    logic [1:0] func;
    logic [7:0] row, col;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      row = 8'($urandom_range(0, 255));
      col = 8'($urandom_range(0, 255));
    end else begin
      row = 8'(rb + $urandom_range(0, 9));
      col = 8'(cb + $urandom_range(0, 9));
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) func = FUNC_LOAD;
    else if (pick < 50) func = FUNC_READ;
    else if (pick < 95) func = FUNC_NOISE;
    else func = FUNC_UNUSED;
    if (!sb.readable(func, row, col)) func = FUNC_LOAD;
    send(func, row, col, 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic write_field(reg_idx_t idx, logic [8:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_config(idx, data);
  endtask

  task automatic configure(logic [1:0] dir, logic bnd, logic [8:0] w, logic [8:0] h);
    write_field(REG_DIRECTION, 9'(dir));
    write_field(REG_BOUNDARY, 9'(bnd));
    write_field(REG_WIDTH, w);
    write_field(REG_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_LOAD;
    item_ch.row = '0;
    item_ch.col = '0;
    item_ch.pixel_in = 1'b0;
    item_ch.random_bit = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DIRECTION;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  initial begin : result_sink
    int gap, taken;
    pix_result_t got;
    taken = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (taken % 50 == 0) quiet_recv = ($urandom_range(0, 2) == 0);
      // hold off long enough for the block to fill and stall its input
      if (taken == 150 || taken == 900) gap = 400;
      else gap = quiet_recv ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.pixel_out = res_ch.pixel_out;
      got.changed = res_ch.changed;
      got.coord_error = res_ch.coord_error;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int w, h;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners under the reset settings
    send(FUNC_LOAD, 8'd0, 8'd0, 1'b1, 1'b0);
    send(FUNC_LOAD, 8'd255, 8'd255, 1'b0, 1'b0);
    send(FUNC_LOAD, 8'd0, 8'd255, 1'b1, 1'b0);
    send(FUNC_LOAD, 8'd255, 8'd0, 1'b1, 1'b0);
    send(FUNC_READ, 8'd0, 8'd0, 1'b0, 1'b1);
    send(FUNC_READ, 8'd255, 8'd255, 1'b1, 1'b0);
    send(FUNC_NOISE, 8'd0, 8'd0, 1'b0, 1'b0);
    send(FUNC_NOISE, 8'd255, 8'd255, 1'b0, 1'b1);
    send(FUNC_NOISE, 8'd0, 8'd255, 1'b0, 1'b1);
    send(FUNC_UNUSED, 8'd7, 8'd9, 1'b1, 1'b1);
    drain();

    // boundary check on a small field, then coordinates off its edges
    configure(DIR_ONE, 1'b1, 9'd4, 9'd3);
    send(FUNC_LOAD, 8'd1, 8'd1, 1'b0, 1'b0);
    send(FUNC_LOAD, 8'd0, 8'd1, 1'b0, 1'b0);
    send(FUNC_LOAD, 8'd1, 8'd0, 1'b0, 1'b0);
    send(FUNC_LOAD, 8'd1, 8'd2, 1'b1, 1'b0);
    send(FUNC_LOAD, 8'd2, 8'd1, 1'b0, 1'b0);
    send(FUNC_NOISE, 8'd1, 8'd1, 1'b0, 1'b0);
    send(FUNC_NOISE, 8'd0, 8'd0, 1'b0, 1'b0);
    send(FUNC_READ, 8'd3, 8'd0, 1'b0, 1'b0);
    send(FUNC_LOAD, 8'd0, 8'd4, 1'b1, 1'b0);
    send(FUNC_READ, 8'd255, 8'd255, 1'b0, 1'b0);
    drain();

    // zero height leaves every coordinate outside
    configure(DIR_ZERO, 1'b0, 9'd511, 9'd0);
    send(FUNC_NOISE, 8'd0, 8'd0, 1'b0, 1'b0);
    drain();

    // spare direction code behaves as symmetric; oversized width clamps
    configure(DIR_ALT, 1'b0, 9'd300, 9'd256);
    send(FUNC_NOISE, 8'd0, 8'd255, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < NumFixed + RandomPhases; p++) begin
      if (p < NumFixed) begin
        configure(2'(ph_dir[p]), 1'(ph_bnd[p]), 9'(ph_w[p]), 9'(ph_h[p]));
        for (int i = 0; i < ItemsPerPhase; i++) send_random_item(ph_rb[p], ph_cb[p]);
      end else begin
        w = $urandom_range(2, 24);
        h = $urandom_range(2, 24);
        configure(2'($urandom_range(0, 3)), 1'($urandom), 9'(w), 9'(h));
        for (int i = 0; i < ItemsPerPhase; i++)
          send_random_item($urandom_range(0, h), $urandom_range(0, w));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bmsp_pkg.sv
design/bmsp_item_if.sv
design/bmsp_result_if.sv
design/bmsp_cfg_if.sv
design/bmsp_cfg.sv
design/bmsp_mem.sv
design/bmsp_seq.sv
design/bit_mask_salt_pepper_noise.sv
test/testbench.sv
